// ===== rtl/snx_pkg.sv =====
// Shared constants and types for the four-dimensional simplex noise block.
// Depends on nothing; imported by the top level and the testbench.
`default_nettype none

package snx_pkg;

	// Permutation table geometry.
	localparam int PERM_SIZE = 256;
	localparam int PERM_AW   = 8;

	// Default number of fractional bits in the input coordinates.
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Reset value of the frequency register, 1.0 in Q8.8.
	localparam logic [15:0] COORD_SCALE_RST = 16'd256;

	// Skew factor (sqrt5-1)/4 in Q0.20 and unskew factor (5-sqrt5)/20 in Q0.24.
	localparam logic [18:0] SKEW_Q20   = 19'd324028;
	localparam logic [21:0] UNSKEW_Q24 = 22'd2318554;
	// Unskew factor in Q16, added once for each step along the simplex.
	localparam int          UNSKEW_Q16 = 9057;

	// Radius squared of a corner's influence, 0.6 in Q32.
	localparam logic [37:0] ATTEN_Q32 = 38'd2576980378;

	// Lattice geometry.
	localparam int NAXIS   = 4;
	localparam int NCORNER = 5;
	localparam int NLEVEL  = 4;

	// Item kinds.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	// Number of pipeline stages between the input and the output register.
	localparam int PIPE_DEPTH = 15;

	// Control that travels with every item down the pipeline.
	typedef struct packed {
		logic       vld;
		logic       eval;
		logic [7:0] idx;
		logic [7:0] val;
	} stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/simplex_noise_4d.sv =====
// Top level of the four-dimensional simplex noise evaluator.
// Depends on snx_pkg for constants and types and on snx_ram for the table copies.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -----------------------------------------------
//  command   start / busy            mode, perm_index, perm_value, coord_x..coord_w
//  result    done (strobe)           noise_value
//  config    cfg_valid / cfg_ready   cfg_data (coord_scale)
//
// One item is taken in every cycle; busy never rises and cfg_ready is always high.
// An evaluation shows its result on done once it has passed through the
// fifteen pipeline stages and the output register.
// The permutation table is held as twenty RAM copies, one for each hash level and
// corner, each written when a load reaches the stage that reads that copy.
// Reset clears the stage valid bits, the output strobe and the frequency register;
// the table contents are undefined until loaded. The receiver cannot stall.
`default_nettype none

module simplex_noise_4d #(
	parameter int COORD_FRAC_BITS = snx_pkg::COORD_FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [7:0]  perm_index,
	input  wire logic [7:0]  perm_value,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic signed [31:0] coord_w,
	output logic             done,
	output logic signed [15:0] noise_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	import snx_pkg::*;

	localparam int F   = COORD_FRAC_BITS;
	localparam int LAT = PIPE_DEPTH + 1;

	// Sum of the three non-zero gradient components applied to one corner offset.
	function automatic logic signed [19:0] grad_dot(input logic [4:0] g,
			input logic signed [17:0] d0v, input logic signed [17:0] d1v,
			input logic signed [17:0] d2v, input logic signed [17:0] d3v);
		logic signed [17:0] dv [4];
		logic [1:0]         zax;
		logic signed [19:0] acc;
		int                 j;
		dv[0] = d0v;
		dv[1] = d1v;
		dv[2] = d2v;
		dv[3] = d3v;
		zax   = g[4:3];
		acc   = '0;
		for (int i = 0; i < NAXIS; i++) begin
			if (i != int'(zax)) begin
				j = (i > int'(zax)) ? i - 1 : i;
				if (g[2-j]) begin
					acc = acc - 20'(dv[i]);
				end else begin
					acc = acc + 20'(dv[i]);
				end
			end
		end
		return acc;
	endfunction

	// Frequency register; the configuration channel never pushes back.
	logic [15:0] coord_scale_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_scale_q <= COORD_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			coord_scale_q <= cfg_data;
		end
	end

	// Item control shift line: valid, kind and load payload for every stage.
	stage_ctl_t ctl_s [1:PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= PIPE_DEPTH; s++) begin
				ctl_s[s] <= '0;
			end
		end else begin
			ctl_s[1].vld  <= start && !busy;
			ctl_s[1].eval <= (mode == MODE_EVAL);
			ctl_s[1].idx  <= perm_index;
			ctl_s[1].val  <= perm_value;
			for (int s = 2; s <= PIPE_DEPTH; s++) begin
				ctl_s[s] <= ctl_s[s-1];
			end
		end
	end

	// Stage 1: scale each coordinate by the Q8.8 frequency factor.
	logic signed [31:0] crd [NAXIS];
	logic signed [48:0] scl_prod [NAXIS];
	logic signed [39:0] xc_s1 [NAXIS];

	assign crd[0] = coord_x;
	assign crd[1] = coord_y;
	assign crd[2] = coord_z;
	assign crd[3] = coord_w;

	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			scl_prod[i] = crd[i] * $signed({1'b0, coord_scale_q});
		end
	end

	// Stage 2: sum of the scaled coordinates.
	logic signed [39:0] xc_s2 [NAXIS];
	logic signed [41:0] sum_s2;

	// Stage 3: skew product in two partial products.
	logic signed [39:0] xc_s3 [NAXIS];
	logic        [39:0] plo_s3;
	logic signed [40:0] phi_s3;

	// Stage 4: skew offset.
	logic signed [39:0] xc_s4 [NAXIS];
	logic signed [40:0] skew_s4;
	logic signed [60:0] skew_prod;

	assign skew_prod = (61'(phi_s3) <<< 21) + $signed({21'b0, plo_s3});

	always_ff @(posedge clk) begin
		for (int i = 0; i < NAXIS; i++) begin
			xc_s1[i] <= scl_prod[i][47:8];
			xc_s2[i] <= xc_s1[i];
			xc_s3[i] <= xc_s2[i];
			xc_s4[i] <= xc_s3[i];
		end
		sum_s2  <= 42'(xc_s1[0]) + 42'(xc_s1[1]) + 42'(xc_s1[2]) + 42'(xc_s1[3]);
		plo_s3  <= sum_s2[20:0] * SKEW_Q20;
		phi_s3  <= $signed(sum_s2[41:21]) * $signed({1'b0, SKEW_Q20});
		skew_s4 <= skew_prod[60:20];
	end

	// Stage 5: lattice cell and Q16 fraction of each skewed coordinate.
	logic signed [42:0] ucrd [NAXIS];
	logic        [15:0] f16_c [NAXIS];
	logic        [7:0]  cell_s5 [NAXIS];
	logic        [15:0] f16_s5 [NAXIS];
	logic        [17:0] fsum_s5;

	for (genvar gi = 0; gi < NAXIS; gi++) begin : g_frac
		assign ucrd[gi] = 43'(xc_s4[gi]) + 43'(skew_s4);
		if (F >= 16) begin : g_down
			assign f16_c[gi] = ucrd[gi][F-1 -: 16];
		end else begin : g_up
			assign f16_c[gi] = {ucrd[gi][F-1:0], {(16-F){1'b0}}};
		end
	end

	// Stage 6: unskew term and corner order from the ranked fractions.
	logic [39:0] unskew_prod;
	logic [1:0]  rnk [NAXIS];
	logic [3:0]  off_c [NCORNER];
	logic        xy, xz, xw, yz, yw, zw;
	logic [15:0] t_s6;
	logic [15:0] f16_s6 [NAXIS];
	logic [7:0]  cell_s6 [NAXIS];
	logic [3:0]  off_s6 [NCORNER];

	assign unskew_prod = fsum_s5 * UNSKEW_Q24;

	// Ties go to the later axis, so every point has a valid order.
	always_comb begin
		xy = f16_s5[0] > f16_s5[1];
		xz = f16_s5[0] > f16_s5[2];
		xw = f16_s5[0] > f16_s5[3];
		yz = f16_s5[1] > f16_s5[2];
		yw = f16_s5[1] > f16_s5[3];
		zw = f16_s5[2] > f16_s5[3];
		rnk[0] = 2'(xy) + 2'(xz) + 2'(xw);
		rnk[1] = 2'(!xy) + 2'(yz) + 2'(yw);
		rnk[2] = 2'(!xz) + 2'(!yz) + 2'(zw);
		rnk[3] = 2'(!xw) + 2'(!yw) + 2'(!zw);
		for (int k = 0; k < NCORNER; k++) begin
			for (int i = 0; i < NAXIS; i++) begin
				off_c[k][i] = (k != 0) && ((3'(rnk[i]) + 3'(k)) >= 3'd4);
			end
		end
	end

	// Stage 7: first corner offset; stage 8: offsets of all five corners.
	logic signed [17:0] d0_s7 [NAXIS];
	logic [7:0]  cell_s7 [NAXIS];
	logic [3:0]  off_s7 [NCORNER];
	logic signed [19:0] dwide [NCORNER][NAXIS];
	logic signed [17:0] d_s8 [NCORNER][NAXIS];
	logic [7:0]  cell_s8 [NAXIS];
	logic [3:0]  off_s8 [NCORNER];

	always_comb begin
		for (int k = 0; k < NCORNER; k++) begin
			for (int i = 0; i < NAXIS; i++) begin
				dwide[k][i] = 20'(d0_s7[i]) - $signed({3'b0, off_s7[k][i], 16'b0})
					+ 20'(k * UNSKEW_Q16);
			end
		end
	end

	// Stage 9: squares; stage 10: attenuation; stage 11 and 12: its powers.
	logic [35:0] sq_s9 [NCORNER][NAXIS];
	logic signed [17:0] d_s9 [NCORNER][NAXIS];
	logic [7:0]  cell_s9 [NAXIS];
	logic [3:0]  off_s9 [NCORNER];
	logic [37:0] r2_c [NCORNER];
	logic [37:0] att_c [NCORNER];
	logic [15:0] a16_s10 [NCORNER];
	logic        pos_s10 [NCORNER];
	logic signed [17:0] d_s10 [NCORNER][NAXIS];
	logic [7:0]  cell_s10 [NAXIS];
	logic [3:0]  off_s10 [NCORNER];
	logic [31:0] a2_prod [NCORNER];
	logic [15:0] a2_s11 [NCORNER];
	logic        pos_s11 [NCORNER];
	logic signed [17:0] d_s11 [NCORNER][NAXIS];
	logic [31:0] a4_prod [NCORNER];
	logic [15:0] a4_s12 [NCORNER];
	logic        pos_s12 [NCORNER];
	logic signed [19:0] dot_s12 [NCORNER];
	logic signed [19:0] dot_c [NCORNER];

	always_comb begin
		for (int k = 0; k < NCORNER; k++) begin
			r2_c[k]    = 38'(sq_s9[k][0]) + 38'(sq_s9[k][1])
				+ 38'(sq_s9[k][2]) + 38'(sq_s9[k][3]);
			att_c[k]   = ATTEN_Q32 - r2_c[k];
			a2_prod[k] = a16_s10[k] * a16_s10[k];
			a4_prod[k] = a2_s11[k] * a2_s11[k];
		end
	end

	// Hash chain: one table copy per level and corner, read one level a stage.
	logic [7:0] hash_addr [NLEVEL][NCORNER];
	logic [7:0] hash_q    [NLEVEL][NCORNER];

	for (genvar gk = 0; gk < NCORNER; gk++) begin : g_corner
		assign hash_addr[0][gk] = cell_s7[3] + 8'(off_s7[gk][3]);
		assign hash_addr[1][gk] = cell_s8[2] + 8'(off_s8[gk][2]) + hash_q[0][gk];
		assign hash_addr[2][gk] = cell_s9[1] + 8'(off_s9[gk][1]) + hash_q[1][gk];
		assign hash_addr[3][gk] = cell_s10[0] + 8'(off_s10[gk][0]) + hash_q[2][gk];

		assign dot_c[gk] = grad_dot(hash_q[3][gk][4:0], d_s11[gk][0], d_s11[gk][1],
			d_s11[gk][2], d_s11[gk][3]);

		for (genvar gl = 0; gl < NLEVEL; gl++) begin : g_level
			// A load writes this copy at the stage where evaluations read it.
			snx_ram #(
				.WIDTH(8),
				.DEPTH(PERM_SIZE)
			) u_perm (
				.clk  (clk),
				.we   (ctl_s[7+gl].vld && !ctl_s[7+gl].eval),
				.waddr(ctl_s[7+gl].idx[PERM_AW-1:0]),
				.wdata(ctl_s[7+gl].val),
				.raddr(hash_addr[gl][gk]),
				.rdata(hash_q[gl][gk])
			);
		end
	end

	// Stage 13: contributions; stage 14: total; stage 15: gain of 27.
	logic signed [36:0] term_s13 [NCORNER];
	logic signed [39:0] total_s14;
	logic signed [44:0] gain_s15;
	logic signed [27:0] res_c;
	logic signed [15:0] noise_q;
	logic               done_q;

	assign res_c = gain_s15[44:17];

	// Datapath stage registers from stage 5 onwards.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NAXIS; i++) begin
			cell_s5[i]  <= ucrd[i][F+7:F];
			f16_s5[i]   <= f16_c[i];
			f16_s6[i]   <= f16_s5[i];
			cell_s6[i]  <= cell_s5[i];
			d0_s7[i]    <= $signed({2'b0, f16_s6[i]}) - $signed({2'b0, t_s6});
			cell_s7[i]  <= cell_s6[i];
			cell_s8[i]  <= cell_s7[i];
			cell_s9[i]  <= cell_s8[i];
			cell_s10[i] <= cell_s9[i];
		end
		fsum_s5 <= 18'(f16_c[0]) + 18'(f16_c[1]) + 18'(f16_c[2]) + 18'(f16_c[3]);
		t_s6    <= unskew_prod[39:24];
		for (int k = 0; k < NCORNER; k++) begin
			off_s6[k]  <= off_c[k];
			off_s7[k]  <= off_s6[k];
			off_s8[k]  <= off_s7[k];
			off_s9[k]  <= off_s8[k];
			off_s10[k] <= off_s9[k];
			for (int i = 0; i < NAXIS; i++) begin
				d_s8[k][i]  <= dwide[k][i][17:0];
				sq_s9[k][i] <= d_s8[k][i] * d_s8[k][i];
				d_s9[k][i]  <= d_s8[k][i];
				d_s10[k][i] <= d_s9[k][i];
				d_s11[k][i] <= d_s10[k][i];
			end
			pos_s10[k]  <= r2_c[k] < ATTEN_Q32;
			a16_s10[k]  <= att_c[k][31:16];
			a2_s11[k]   <= a2_prod[k][31:16];
			pos_s11[k]  <= pos_s10[k];
			a4_s12[k]   <= a4_prod[k][31:16];
			pos_s12[k]  <= pos_s11[k];
			dot_s12[k]  <= dot_c[k];
			term_s13[k] <= pos_s12[k] ? $signed({1'b0, a4_s12[k]}) * dot_s12[k] : 37'sd0;
		end
		total_s14 <= 40'(term_s13[0]) + 40'(term_s13[1]) + 40'(term_s13[2])
			+ 40'(term_s13[3]) + 40'(term_s13[4]);
		gain_s15  <= (45'(total_s14) <<< 4) + (45'(total_s14) <<< 3)
			+ (45'(total_s14) <<< 1) + 45'(total_s14);
		// Saturate the Q1.15 result.
		if (res_c > 28'sd32767) begin
			noise_q <= 16'sh7fff;
		end else if (res_c < -28'sd32768) begin
			noise_q <= -16'sh8000;
		end else begin
			noise_q <= res_c[15:0];
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[PIPE_DEPTH].vld && ctl_s[PIPE_DEPTH].eval;
		end
	end

	assign done        = done_q;
	assign noise_value = noise_q;

	// An evaluation transfer always produces a result on done.
	a_eval_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_EVAL) |-> ##LAT done)
		else $error("evaluation transfer did not produce a result");

	// A table load never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_LOAD) |-> ##LAT !done)
		else $error("table load produced a result");

	// A configuration transfer lands in the frequency register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (coord_scale_q == $past(cfg_data)))
		else $error("configuration transfer lost");

endmodule

`default_nettype wire

// ===== rtl/snx_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for every copy of the permutation table.
`default_nettype none

module snx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== test/tb_simplex_noise_4d.sv =====
// Self-checking testbench for simplex_noise_4d: table loads, evaluations and scale settings.
// Depends on snx_pkg and the simplex_noise_4d RTL; predicts every result with its own model.
`timescale 1ns / 1ps
`default_nettype none

module tb_simplex_noise_4d;
	import snx_pkg::*;

	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 3000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [7:0]  perm_index;
	logic [7:0]  perm_value;
	logic signed [31:0] coord_x, coord_y, coord_z, coord_w;
	logic        done;
	logic signed [15:0] noise_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Shadow copies of the table and the frequency register.
	logic [7:0]  shadow_perm [PERM_SIZE];
	logic [15:0] shadow_scale;
	logic signed [15:0] pending_noise [$];
	int          error_count;
	int          idle_pct;
	int          stall_cycles;

	simplex_noise_4d u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.perm_index(perm_index), .perm_value(perm_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .coord_w(coord_w),
		.done(done), .noise_value(noise_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Hash one corner through the shadow table down to a gradient number.
	function automatic int grad_of_corner(input int lat_cell[4], input int ofs[4]);
		int h;
		h = shadow_perm[(lat_cell[3] + ofs[3]) & 255];
		h = shadow_perm[(lat_cell[2] + ofs[2] + h) & 255];
		h = shadow_perm[(lat_cell[1] + ofs[1] + h) & 255];
		h = shadow_perm[(lat_cell[0] + ofs[0] + h) & 255];
		return h & 31;
	endfunction

	// Attenuated gradient contribution of one corner, in Q32.
	function automatic longint corner_contrib(input longint d[4], input int g);
		longint r2, a, a16, a2, a4, dot;
		int zero_axis, b;
		r2 = 0;
		dot = 0;
		b = 2;
		zero_axis = (g >> 3) & 3;
		for (int i = 0; i < 4; i++)
			r2 += d[i] * d[i];
		a = 64'sd2576980378 - r2;
		if (a <= 0)
			return 0;
		a16 = a >>> 16;
		a2 = (a16 * a16) >>> 16;
		a4 = (a2 * a2) >>> 16;
		for (int i = 0; i < 4; i++) begin
			if (i != zero_axis) begin
				if ((g >> b) & 1)
					dot -= d[i];
				else
					dot += d[i];
				b--;
			end
		end
		return a4 * dot;
	endfunction

	// Expected noise value for one point under the current scale and table.
	function automatic logic signed [15:0] predict_noise(input logic signed [31:0] cx,
			input logic signed [31:0] cy, input logic signed [31:0] cz,
			input logic signed [31:0] cw);
		longint xc[4], f16[4], d0[4], d[4];
		longint sum, skew, fsum, unskew, total, res, u;
		int lat_cell[4], rnk[4], ofs[4];
		int xy, xz, yz, xw, yw, zw;
		logic signed [31:0] c[4];
		c = '{cx, cy, cz, cw};
		sum = 0;
		fsum = 0;
		total = 0;
		for (int i = 0; i < 4; i++) begin
			xc[i] = (longint'(c[i]) * longint'({1'b0, shadow_scale})) >>> 8;
			sum += xc[i];
		end
		skew = (sum * 324028) >>> 20;
		for (int i = 0; i < 4; i++) begin
			u = xc[i] + skew;
			f16[i] = u & 64'hFFFF;
			lat_cell[i] = int'((u >>> 16) & 255);
			fsum += f16[i];
		end
		unskew = (fsum * 2318554) >>> 24;
		for (int i = 0; i < 4; i++)
			d0[i] = f16[i] - unskew;
		// Rank the offset components; ties go to the later axis.
		xy = d0[0] > d0[1];
		xz = d0[0] > d0[2];
		yz = d0[1] > d0[2];
		xw = d0[0] > d0[3];
		yw = d0[1] > d0[3];
		zw = d0[2] > d0[3];
		rnk[0] = xy + xz + xw;
		rnk[1] = (1 - xy) + yz + yw;
		rnk[2] = (1 - xz) + (1 - yz) + zw;
		rnk[3] = (1 - xw) + (1 - yw) + (1 - zw);
		for (int k = 0; k < 5; k++) begin
			for (int i = 0; i < 4; i++) begin
				ofs[i] = (k == 0) ? 0 : ((rnk[i] + k >= 4) ? 1 : 0);
				d[i] = d0[i] - longint'(ofs[i]) * 65536 + longint'(k) * 9057;
			end
			total += corner_contrib(d, grad_of_corner(lat_cell, ofs));
		end
		res = (total * 27) >>> 17;
		if (res > 32767)
			res = 32767;
		if (res < -32768)
			res = -32768;
		return res[15:0];
	endfunction

	// Track accepted transfers: update shadows and queue expected results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				shadow_scale <= cfg_data;
			if (start && !busy) begin
				if (mode == MODE_LOAD)
					shadow_perm[perm_index] <= perm_value;
				else
					pending_noise.push_back(predict_noise(coord_x, coord_y, coord_z, coord_w));
			end
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && done) begin
			if (pending_noise.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, noise_value);
				error_count++;
			end else begin
				want = pending_noise.pop_front();
				if (noise_value !== want) begin
					$display("%0t: noise_value mismatch, expected %0d, actual %0d",
						$time, want, noise_value);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer or result.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Send one item; each cycle beforehand is idle with the chosen probability.
	task automatic send_item(input logic m, input logic [7:0] idx, input logic [7:0] val,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [31:0] w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		mode       <= m;
		perm_index <= idx;
		perm_value <= val;
		coord_x    <= x;
		coord_y    <= y;
		coord_z    <= z;
		coord_w    <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [31:0] w);
		send_item(MODE_EVAL, 8'($urandom), 8'($urandom), x, y, z, w);
	endtask

	// Let the pipeline empty, then wait out the latency of any trailing load.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_noise.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the frequency register while the block is idle.
	task automatic write_scale(input logic [15:0] scale);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data  <= scale;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random coordinate: mostly a few cells wide, sometimes any 32-bit value.
	function automatic logic signed [31:0] rand_coord();
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
	endfunction

	// Fill the whole table with a shuffled permutation.
	task automatic test_table_load();
		logic [7:0] perm [PERM_SIZE];
		int j;
		logic [7:0] tmp;
		for (int i = 0; i < PERM_SIZE; i++)
			perm[i] = i[7:0];
		for (int i = PERM_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (int i = 0; i < PERM_SIZE; i++)
			send_item(MODE_LOAD, i[7:0], perm[i], $urandom, $urandom, $urandom, $urandom);
	endtask

	// Extreme coordinates, tied components and cells far from the origin.
	task automatic test_extremes();
		send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_point(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
		send_point(0, 0, 0, 0);
		send_point(32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000);
		send_point(32'sh4000, 32'sh4000, 32'sh2000, 32'sh2000);
		send_point(32'sh1234, 32'sh5678, 32'sh1234, 32'sh5678);
		send_point(-1, -1, -1, -1);
		send_point(32'sh0123_4567, 32'shFEDC_BA98, 32'sh00FF_8000, 32'shFF00_4000);
		send_point(32'sh0001_8000, 32'sh0002_4000, 32'shFFFF_C000, 32'sh0000_2000);
	endtask

	// Random mix of evaluations and table rewrites.
	task automatic test_random(input int count);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 12)
				send_item(MODE_LOAD, 8'($urandom), 8'($urandom),
					$urandom, $urandom, $urandom, $urandom);
			else
				send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// Several register settings, the extremes among them.
	task automatic test_scale_settings();
		write_scale(16'd0);
		test_extremes();
		test_random(20);
		write_scale(16'hFFFF);
		test_extremes();
		test_random(20);
		write_scale(16'd64);
		test_random(20);
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_LOAD;
		perm_index   = '0;
		perm_value   = '0;
		coord_x      = '0;
		coord_y      = '0;
		coord_z      = '0;
		coord_w      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		shadow_scale = COORD_SCALE_RST;
		idle_pct     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_extremes();
		test_scale_settings();
		write_scale(COORD_SCALE_RST);

		idle_pct = 19;
		test_random(250);
		write_scale(16'd512);
		idle_pct = 69;
		test_random(250);
		write_scale(16'($urandom));
		idle_pct = 0;
		test_random(250);

		drain_pipeline();
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/snx_pkg.sv
rtl/snx_ram.sv
rtl/simplex_noise_4d.sv
test/tb_simplex_noise_4d.sv
